>>> hdl/qse_pkg.sv
// Shared widths, codes and controller command type for the quadrature speed estimator.
package qse_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int SPEED_WIDTH = 48;
  localparam int SCALE_WIDTH = 32;
  localparam int ALPHA_WIDTH = 17;
  localparam int FRAC_BITS   = 16;

  localparam int PROD_WIDTH  = COUNT_WIDTH + SCALE_WIDTH + 1;
  localparam int DIFF_WIDTH  = SPEED_WIDTH + 1;
  localparam int FPROD_WIDTH = DIFF_WIDTH + ALPHA_WIDTH + 1;

  localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1) << FRAC_BITS;

  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  // Request function codes
  localparam logic [1:0] FUNC_EDGE_A = 2'd0;
  localparam logic [1:0] FUNC_EDGE_B = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_SPEED_SCALE   = 2'd0;
  localparam logic [1:0] REG_LP_WEIGHT     = 2'd1;
  localparam logic [1:0] REG_REVERSE_DIR   = 2'd2;

  localparam logic [SCALE_WIDTH-1:0] SPEED_SCALE_RESET = SCALE_WIDTH'(65536);
  localparam logic [ALPHA_WIDTH-1:0] LP_WEIGHT_RESET   = ALPHA_WIDTH'(32768);

  typedef struct packed {
    logic count_edge;
    logic capture;
    logic multiply;
    logic saturate;
    logic filter;
    logic finish;
  } dp_cmd_t;

endpackage

>>> hdl/qse_ifs.sv
// Valid/ready channel interfaces for edge/tick requests and speed results.
interface qse_req_if;
  import qse_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       phase_a;
  logic       phase_b;
  modport source (output valid, func, phase_a, phase_b, input ready);
  modport sink   (input valid, func, phase_a, phase_b, output ready);
endinterface

interface qse_res_if;
  import qse_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] sampled_count;
  logic signed [SPEED_WIDTH-1:0] raw_speed;
  logic signed [SPEED_WIDTH-1:0] filtered_speed;
  modport source (output valid, sampled_count, raw_speed, filtered_speed, input ready);
  modport sink   (input valid, sampled_count, raw_speed, filtered_speed, output ready);
endinterface

>>> hdl/qse_ctrl.sv
// Sequencer: accepts requests, steps the datapath through a tick, owns result valid.
module qse_ctrl
  import qse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_func,
  output logic       req_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SAT    = 3'd2;
  localparam logic [2:0] ST_FILT   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       res_valid_next;

  always_comb begin
    state_next     = state;
    res_valid_next = res_valid && !res_ready;
    cmd            = '0;
    req_ready      = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_func)
            FUNC_EDGE_A, FUNC_EDGE_B: begin
              cmd.count_edge = 1'b1;
            end
            FUNC_TICK: begin
              cmd.capture = 1'b1;
              state_next  = ST_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = ST_SAT;
      end
      ST_SAT: begin
        cmd.saturate = 1'b1;
        state_next   = ST_FILT;
      end
      ST_FILT: begin
        cmd.filter = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!res_valid || res_ready) begin
          cmd.finish     = 1'b1;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

>>> hdl/qse_dpath.sv
// Datapath: saturating edge counter, scale multiply, saturation and low-pass filter.
module qse_dpath
  import qse_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  input  logic                          edge_on_b,
  input  logic                          phase_a,
  input  logic                          phase_b,
  input  logic [SCALE_WIDTH-1:0]        speed_scale,
  input  logic [ALPHA_WIDTH-1:0]        lp_weight,
  input  logic                          reverse_direction,
  output logic signed [COUNT_WIDTH-1:0] sampled_count,
  output logic signed [SPEED_WIDTH-1:0] raw_speed,
  output logic signed [SPEED_WIDTH-1:0] filtered_speed
);

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = {1'b1, {(SPEED_WIDTH-1){1'b0}}};

  logic signed [COUNT_WIDTH-1:0] edge_count;
  logic signed [COUNT_WIDTH-1:0] cnt_s;
  logic signed [PROD_WIDTH-1:0]  prod;
  logic signed [SPEED_WIDTH-1:0] raw;
  logic signed [SPEED_WIDTH-1:0] last_filtered;
  logic signed [FPROD_WIDTH-1:0] fprod;

  logic                          count_up;
  logic [PROD_WIDTH-SPEED_WIDTH:0] prod_top;
  logic                          prod_fits;
  logic signed [SPEED_WIDTH-1:0] raw_sat;
  logic [ALPHA_WIDTH-1:0]        alpha_c;
  logic signed [DIFF_WIDTH-1:0]  diff;
  logic signed [FPROD_WIDTH-1:0] fshift;
  logic signed [DIFF_WIDTH-1:0]  filt_sum;
  logic signed [SPEED_WIDTH-1:0] filt_new;

  // A edge counts up when the pins agree; B edge and reverse flip it
  assign count_up = (phase_a == phase_b) ^ edge_on_b ^ reverse_direction;

  assign prod_top  = prod[PROD_WIDTH-1:SPEED_WIDTH-1];
  assign prod_fits = (&prod_top) || !(|prod_top);
  assign raw_sat   = prod_fits ? prod[SPEED_WIDTH-1:0]
                               : (prod[PROD_WIDTH-1] ? SPEED_MIN : SPEED_MAX);

  assign alpha_c = (lp_weight > ALPHA_ONE) ? ALPHA_ONE : lp_weight;
  assign diff    = {raw[SPEED_WIDTH-1], raw} - {last_filtered[SPEED_WIDTH-1], last_filtered};

  // floor(alpha * diff / 2^16) + last, always within the speed range
  assign fshift   = fprod >>> FRAC_BITS;
  assign filt_sum = fshift[DIFF_WIDTH-1:0]
                  + {last_filtered[SPEED_WIDTH-1], last_filtered};
  assign filt_new = filt_sum[SPEED_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      last_filtered <= '0;
    end else begin
      if (cmd.count_edge) begin
        if (count_up && edge_count != COUNT_MAX) begin
          edge_count <= edge_count + COUNT_WIDTH'(1);
        end else if (!count_up && edge_count != COUNT_MIN) begin
          edge_count <= edge_count - COUNT_WIDTH'(1);
        end
      end else if (cmd.capture) begin
        edge_count <= '0;
      end
      if (cmd.finish) begin
        last_filtered <= filt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_s <= edge_count;
    end
    if (cmd.multiply) begin
      prod <= $signed(cnt_s) * $signed({1'b0, speed_scale});
    end
    if (cmd.saturate) begin
      raw <= raw_sat;
    end
    if (cmd.filter) begin
      fprod <= $signed(diff) * $signed({1'b0, alpha_c});
    end
    if (cmd.finish) begin
      sampled_count  <= cnt_s;
      raw_speed      <= raw;
      filtered_speed <= filt_new;
    end
  end

endmodule

>>> hdl/quadrature_speed_estimator_unit.sv
// An edge request updates the count when accepted; a tick passes through the accept cycle and
// the scale multiply, saturation, filter multiply and result register steps of the sequencer.
// One edge per cycle while no tick is in progress; requests wait until a tick has finished.
// A finished result waits in the output register while edges are still accepted.
// Reset (synchronous, rst high) clears the edge count, the filter state, result valid,
// and loads the registers with scale 1.0, alpha 0.5, normal direction.
module quadrature_speed_estimator_unit
  import qse_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  qse_req_if.sink                   events,
  qse_res_if.source                 speeds,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic [SCALE_WIDTH-1:0] speed_scale;
  logic [ALPHA_WIDTH-1:0] lp_weight;
  logic                   reverse_direction;
  logic                   cfg_write;
  logic [1:0]             reg_index;
  dp_cmd_t                cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale       <= SPEED_SCALE_RESET;
      lp_weight         <= LP_WEIGHT_RESET;
      reverse_direction <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SPEED_SCALE:  speed_scale       <= pwdata[SCALE_WIDTH-1:0];
        REG_LP_WEIGHT:    lp_weight         <= pwdata[ALPHA_WIDTH-1:0];
        REG_REVERSE_DIR:  reverse_direction <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SPEED_SCALE:  prdata = APB_DATA_WIDTH'(speed_scale);
      REG_LP_WEIGHT:    prdata = APB_DATA_WIDTH'(lp_weight);
      REG_REVERSE_DIR:  prdata = APB_DATA_WIDTH'(reverse_direction);
      default:          prdata = '0;
    endcase
  end

  qse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (events.valid),
    .req_func  (events.func),
    .req_ready (events.ready),
    .res_valid (speeds.valid),
    .res_ready (speeds.ready),
    .cmd       (cmd)
  );

  qse_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .edge_on_b         (events.func[0]),
    .phase_a           (events.phase_a),
    .phase_b           (events.phase_b),
    .speed_scale       (speed_scale),
    .lp_weight         (lp_weight),
    .reverse_direction (reverse_direction),
    .sampled_count     (speeds.sampled_count),
    .raw_speed         (speeds.raw_speed),
    .filtered_speed    (speeds.filtered_speed)
  );

endmodule

>>> tb/sv/qse_speed_scoreboard_pkg.sv
// Speed predictor and result scoreboard for the quadrature speed estimator testbench.
`timescale 1ns / 1ps
package qse_speed_scoreboard_pkg;
  import qse_pkg::*;

  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count;
    logic signed [SPEED_WIDTH-1:0] raw;
    logic signed [SPEED_WIDTH-1:0] filt;
  } speed_sample_t;

  class speed_scoreboard;
    logic [SCALE_WIDTH-1:0]        scale_q16;
    logic [ALPHA_WIDTH-1:0]        alpha_q16;
    logic                          reverse;
    logic signed [COUNT_WIDTH-1:0] edge_total;
    logic signed [SPEED_WIDTH-1:0] smoothed;
    speed_sample_t                 expected_q[$];
    int unsigned                   mismatches;
    int unsigned                   checked;
    int unsigned                   edges;
    int unsigned                   ticks;
    int unsigned                   ignored;

    function new();
      scale_q16  = SPEED_SCALE_RESET;
      alpha_q16  = LP_WEIGHT_RESET;
      reverse    = 1'b0;
      edge_total = '0;
      smoothed   = '0;
      mismatches = 0;
      checked    = 0;
      edges      = 0;
      ticks      = 0;
      ignored    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [APB_DATA_WIDTH-1:0] value);
      case (idx)
        REG_SPEED_SCALE: scale_q16 = value[SCALE_WIDTH-1:0];
        REG_LP_WEIGHT: alpha_q16 = value[ALPHA_WIDTH-1:0];
        REG_REVERSE_DIR: reverse = value[0];
        default: ;
      endcase
    endfunction

    // Note one accepted request; a tick queues the speed sample it must produce.
    function void note_request(input logic [1:0] func, input logic pa, input logic pb);
      longint                  step;
      longint                  next_count;
      longint                  cnt;
      longint                  raw;
      longint                  filt;
      longint                  diff;
      longint                  hi_lim;
      logic signed [127:0]     prod;
      logic [ALPHA_WIDTH-1:0]  a;
      speed_sample_t           sample;
      hi_lim = (longint'(1) <<< (COUNT_WIDTH - 1)) - 1;
      if (func == FUNC_EDGE_A || func == FUNC_EDGE_B) begin
        edges++;
        step = (pa == pb) ? 1 : -1;
        if (func == FUNC_EDGE_B) step = -step;
        if (reverse) step = -step;
        next_count = longint'(edge_total) + step;
        if (next_count > hi_lim) next_count = hi_lim;
        else if (next_count < -hi_lim - 1) next_count = -hi_lim - 1;
        edge_total = COUNT_WIDTH'(next_count);
      end else if (func == FUNC_TICK) begin
        ticks++;
        cnt = longint'(edge_total);
        raw = cnt * longint'({32'd0, scale_q16});
        hi_lim = (longint'(1) <<< (SPEED_WIDTH - 1)) - 1;
        if (raw > hi_lim) raw = hi_lim;
        else if (raw < -hi_lim - 1) raw = -hi_lim - 1;
        a = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
        // floor of alpha * (raw - last) / one, computed wide enough for the full product
        diff = raw - longint'(smoothed);
        prod = diff * $signed({1'b0, a});
        filt = longint'(prod >>> FRAC_BITS) + longint'(smoothed);
        edge_total = '0;
        smoothed = SPEED_WIDTH'(filt);
        sample.count = COUNT_WIDTH'(cnt);
        sample.raw = SPEED_WIDTH'(raw);
        sample.filt = SPEED_WIDTH'(filt);
        expected_q.push_back(sample);
      end else begin
        ignored++;
      end
    endfunction

    function void check_result(input logic signed [COUNT_WIDTH-1:0] count,
                               input logic signed [SPEED_WIDTH-1:0] raw,
                               input logic signed [SPEED_WIDTH-1:0] filt);
      speed_sample_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected speed result: count %0d raw %0d filtered %0d", count, raw, filt);
        return;
      end
      want = expected_q.pop_front();
      if (want.count !== count || want.raw !== raw || want.filt !== filt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("speed mismatch: expected count %0d raw %0d filtered %0d, got %0d %0d %0d",
                   want.count, want.raw, want.filt, count, raw, filt);
      end
    endfunction
  endclass

endpackage

>>> tb/sv/quadrature_speed_estimator_unit_tb.sv
// Top-level testbench for the quadrature speed estimator: stimulus, handshakes and checking.
`timescale 1ns / 1ps
module quadrature_speed_estimator_unit_tb;
  import qse_pkg::*;
  import qse_speed_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SAT_RUN     = 40;

  // Selector value the block ignores
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  logic                      no_idle;
  logic                      hold_off;
  logic                      random_on;
  logic                      pin_a;
  logic                      pin_b;
  int                        cycles;
  int                        settings;

  speed_scoreboard sb = new();

  qse_req_if ev_if ();
  qse_res_if sp_if ();

  quadrature_speed_estimator_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .speeds  (sp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && sp_if.valid && sp_if.ready)
      sb.check_result(sp_if.sampled_count, sp_if.raw_speed, sp_if.filtered_speed);
  end

  // Result receiver: random stalls per result, plus the long hold-offs below.
  initial begin
    int stall;
    sp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0 || hold_off) begin
        sp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      sp_if.ready <= 1'b1;
      do @(posedge clk); while (!sp_if.valid);
    end
  end

  // Hold results back for long stretches so the output register fills and input stalls.
  initial begin
    hold_off <= 1'b0;
    @(posedge clk);
    while (!random_on) @(posedge clk);
    repeat (2) begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      hold_off <= 1'b1;
      repeat (500) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_WIDTH-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Offer one request; valid stays high after acceptance unless the next one idles first.
  task automatic send_request(input logic [1:0] func, input logic pa, input logic pb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid   <= 1'b1;
    ev_if.func    <= func;
    ev_if.phase_a <= pa;
    ev_if.phase_b <= pb;
    do @(posedge clk); while (!ev_if.ready);
    sb.note_request(func, pa, pb);
  endtask

  // Drop valid, wait for every queued result, then let the pipeline empty.
  task automatic drain();
    ev_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Move the shaft one quadrature state forward or backward.
  task automatic turn_shaft(input logic backward);
    logic a_edge;
    a_edge = backward ? (pin_a != pin_b) : (pin_a == pin_b);
    if (a_edge) pin_a = ~pin_a;
    else pin_b = ~pin_b;
    send_request(a_edge ? FUNC_EDGE_A : FUNC_EDGE_B, pin_a, pin_b);
  endtask

  task automatic random_phase(input logic [31:0] scale, input logic [31:0] alpha,
                              input logic rev, input int target);
    int   done;
    int   len;
    logic backward;
    logic [1:0] func;
    write_reg(REG_SPEED_SCALE, scale);
    write_reg(REG_LP_WEIGHT, alpha);
    write_reg(REG_REVERSE_DIR, {31'd0, rev});
    settings++;
    done = 0;
    while (done < target) begin
      no_idle <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        // well-formed rotation followed by a tick
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        backward = 1'($urandom_range(0, 1));
        repeat (len) turn_shaft(backward);
        send_request(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        done += len + 1;
      end else begin
        // noise: glitches, unused selector, stray ticks
        repeat ($urandom_range(1, 6)) begin
          func = 2'($urandom_range(0, 3));
          send_request(func, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          if (func != FUNC_SPARE) done++;
        end
      end
    end
    drain();
  endtask

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    ev_if.valid <= 1'b0;
    ev_if.func  <= FUNC_EDGE_A;
    ev_if.phase_a <= 1'b0;
    ev_if.phase_b <= 1'b0;
    no_idle     <= 1'b0;
    random_on   <= 1'b0;
    pin_a       = 1'b0;
    pin_b       = 1'b0;
    settings    = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every edge direction at reset settings, the unused selector, an empty tick.
    send_request(FUNC_EDGE_A, 1'b0, 1'b0);
    send_request(FUNC_EDGE_A, 1'b1, 1'b0);
    send_request(FUNC_EDGE_A, 1'b0, 1'b1);
    send_request(FUNC_EDGE_A, 1'b1, 1'b1);
    send_request(FUNC_EDGE_B, 1'b0, 1'b0);
    send_request(FUNC_EDGE_B, 1'b1, 1'b0);
    send_request(FUNC_EDGE_B, 1'b0, 1'b1);
    send_request(FUNC_EDGE_B, 1'b1, 1'b1);
    send_request(FUNC_EDGE_A, 1'b1, 1'b1);
    send_request(FUNC_TICK, 1'b0, 1'b0);
    send_request(FUNC_SPARE, 1'b1, 1'b1);
    send_request(FUNC_SPARE, 1'b0, 1'b0);
    send_request(FUNC_EDGE_B, 1'b1, 1'b0);
    send_request(FUNC_EDGE_B, 1'b1, 1'b0);
    send_request(FUNC_TICK, 1'b1, 1'b1);
    send_request(FUNC_TICK, 1'b0, 1'b1);
    drain();

    // Mirrored wheel.
    write_reg(REG_REVERSE_DIR, 32'd1);
    settings++;
    send_request(FUNC_EDGE_A, 1'b0, 1'b0);
    send_request(FUNC_EDGE_A, 1'b0, 1'b0);
    send_request(FUNC_EDGE_B, 1'b1, 1'b0);
    send_request(FUNC_EDGE_A, 1'b1, 1'b0);
    send_request(FUNC_TICK, 1'b1, 1'b0);
    drain();

    // Back-to-back same-direction runs at full scale; an oversized alpha
    // passes the raw speed straight through.
    write_reg(REG_SPEED_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_LP_WEIGHT, 32'h0001_FFFF);
    write_reg(REG_REVERSE_DIR, 32'd0);
    settings++;
    no_idle <= 1'b1;
    repeat (SAT_RUN) send_request(FUNC_EDGE_A, 1'b1, 1'b1);
    send_request(FUNC_TICK, 1'b0, 1'b0);
    repeat (SAT_RUN) send_request(FUNC_EDGE_A, 1'b0, 1'b1);
    send_request(FUNC_TICK, 1'b0, 1'b0);
    no_idle <= 1'b0;
    drain();

    random_on <= 1'b1;
    random_phase(32'd65536, 32'd32768, 1'b0, 240);
    random_phase(32'hFFFF_FFFF, 32'd65536, 1'b1, 240);
    random_phase(32'd0, 32'd0, 1'b0, 200);
    random_phase($urandom(), 32'd131071, 1'b1, 240);
    random_phase($urandom(), $urandom_range(0, 65536), 1'($urandom_range(0, 1)), 240);
    random_phase(32'd1, 32'd1, 1'b0, 200);
    random_phase($urandom(), $urandom_range(65537, 131071), 1'b0, 240);
    random_phase($urandom(), $urandom_range(0, 65536), 1'b1, 260);

    drain();
    $display("run covered %0d edges, %0d ticks and %0d unused requests over %0d settings",
             sb.edges, sb.ticks, sb.ignored, settings);
    $display("%0d speed results checked, %0d mismatches, %0d left over",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
